// ----- rtl/wrrq_pkg.sv -----
package wrrq_pkg;

    localparam int DEF_NUM_QUEUES  = 4;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DATA_WIDTH      = 16;
    localparam int WEIGHT_W        = 8;
    localparam int NUM_WEIGHT_REGS = 4;
    localparam int REQ_W           = 2;
    localparam int STATUS_W        = 2;
    localparam int QSEL_W          = 2;
    localparam int APB_AW          = 4;
    localparam int APB_DW          = 32;

    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [WEIGHT_W-1:0] t_weight;

    localparam t_req REQ_PUT  = 2'd0;
    localparam t_req REQ_TAKE = 2'd1;
    localparam t_req REQ_PEEK = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam t_weight WEIGHT_RESET = 8'd1;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

// ----- rtl/wrrq_ram.sv -----
module wrrq_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/wrrq_ctrl.sv -----
module wrrq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output wrrq_pkg::t_dp_cmd o_cmd
);
    import wrrq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;
    logic       w_accept;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_DONE) && w_out_free);
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_cmd.capture  = w_accept;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.load_out = (r_state == S_DONE) && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = w_accept ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $past(w_accept))
        else $error("exec without an accepted item");

    a_exec_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_DONE))
        else $error("exec not followed by done");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done");

endmodule

// ----- rtl/wrrq_dp.sv -----
module wrrq_dp #(
    parameter int NUM_QUEUES  = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  wrrq_pkg::t_dp_cmd                              i_cmd,
    input  wrrq_pkg::t_req                                 i_req_type,
    input  logic [wrrq_pkg::DATA_WIDTH-1:0]                i_item_value,
    input  logic [wrrq_pkg::QSEL_W-1:0]                    i_queue_select,
    input  logic [NUM_QUEUES-1:0][wrrq_pkg::WEIGHT_W-1:0]  i_weights,
    output logic [wrrq_pkg::DATA_WIDTH-1:0]                o_out_value,
    output wrrq_pkg::t_status                              o_status,
    output logic [wrrq_pkg::QSEL_W-1:0]                    o_out_queue
);
    import wrrq_pkg::*;

    localparam int QW      = $clog2(NUM_QUEUES);
    localparam int PW      = $clog2(QUEUE_DEPTH);
    localparam int FW      = $clog2(QUEUE_DEPTH + 1);
    localparam int MDEPTH  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW      = $clog2(MDEPTH);

    t_req                  r_req;
    logic [DATA_WIDTH-1:0] r_val;
    logic [QSEL_W-1:0]     r_sel;

    logic [PW-1:0]         r_head [NUM_QUEUES];
    logic [PW-1:0]         r_tail [NUM_QUEUES];
    logic [FW-1:0]         r_fill [NUM_QUEUES];
    logic [QW-1:0]         r_cur;
    t_weight               r_cnt;

    t_status               r_res_status;
    logic [QW-1:0]         r_res_queue;
    logic                  r_res_use_ram;

    logic [DATA_WIDTH-1:0] r_out_value;
    t_status               r_out_status;
    logic [QSEL_W-1:0]     r_out_queue;

    logic [NUM_QUEUES-1:0] w_elig;
    logic                  w_start_ok;
    logic                  w_found;
    logic [QW-1:0]         w_q;
    t_weight               w_cnt;
    t_weight               w_cnt_inc;
    logic [QW:0]           w_idx;
    logic [QW-1:0]         w_selq;
    logic                  w_sel_ok;
    logic                  w_put_ok;
    logic                  w_is_get;
    logic                  w_we;
    logic                  w_re;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    function automatic logic [PW-1:0] f_wrap(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [QW-1:0] f_next_q(input logic [QW-1:0] q);
        return (q == QW'(NUM_QUEUES - 1)) ? '0 : q + QW'(1);
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [QW-1:0] q,
                                             input logic [PW-1:0] p);
        return AW'(AW'(q) * AW'(QUEUE_DEPTH)) + AW'(p);
    endfunction

    always_comb begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
            w_elig[q] = (r_fill[q] != '0) && (i_weights[q] != '0);
        end
    end

    always_comb begin
        w_start_ok = (r_fill[r_cur] != '0) && (r_cnt < i_weights[r_cur]);
        w_found    = w_start_ok;
        w_q        = r_cur;
        w_cnt      = r_cnt;
        w_idx      = '0;
        if (!w_start_ok) begin
            for (int k = NUM_QUEUES; k >= 1; k--) begin
                w_idx = {1'b0, r_cur} + (QW + 1)'(k);
                if (w_idx >= (QW + 1)'(NUM_QUEUES)) begin
                    w_idx = w_idx - (QW + 1)'(NUM_QUEUES);
                end
                if (w_elig[w_idx[QW-1:0]]) begin
                    w_found = 1'b1;
                    w_q     = w_idx[QW-1:0];
                    w_cnt   = '0;
                end
            end
        end
    end

    assign w_cnt_inc = w_cnt + t_weight'(1);
    assign w_selq    = QW'(r_sel);
    assign w_sel_ok  = 32'(r_sel) < 32'(NUM_QUEUES);
    assign w_put_ok  = w_sel_ok && (r_fill[w_selq] != FW'(QUEUE_DEPTH));
    assign w_is_get  = (r_req == REQ_TAKE) || (r_req == REQ_PEEK);

    assign w_we    = i_cmd.exec && (r_req == REQ_PUT) && w_put_ok;
    assign w_re    = i_cmd.exec && w_is_get && w_found;
    assign w_waddr = f_addr(w_selq, r_tail[w_selq]);
    assign w_raddr = f_addr(w_q, r_head[w_q]);

    wrrq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MDEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_val),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_type;
            r_val <= i_item_value;
            r_sel <= i_queue_select;
        end
        if (i_cmd.exec) begin
            r_res_status  <= ST_OK;
            r_res_queue   <= '0;
            r_res_use_ram <= 1'b0;
            unique case (r_req)
                REQ_PUT: begin
                    if (!w_put_ok) begin
                        r_res_status <= ST_FULL;
                    end
                end
                REQ_TAKE, REQ_PEEK: begin
                    if (w_found) begin
                        r_res_queue   <= w_q;
                        r_res_use_ram <= 1'b1;
                    end else begin
                        r_res_status <= ST_EMPTY;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.load_out) begin
            r_out_value  <= r_res_use_ram ? w_rdata : '0;
            r_out_status <= r_res_status;
            r_out_queue  <= QSEL_W'(r_res_queue);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
                r_fill[q] <= '0;
            end
            r_cur <= '0;
            r_cnt <= '0;
        end else if (i_cmd.exec) begin
            if (w_we) begin
                r_tail[w_selq] <= f_wrap(r_tail[w_selq]);
                r_fill[w_selq] <= r_fill[w_selq] + FW'(1);
            end
            if (w_re) begin
                r_cur <= w_q;
                r_cnt <= w_cnt;
                if (r_req == REQ_TAKE) begin
                    r_head[w_q] <= f_wrap(r_head[w_q]);
                    r_fill[w_q] <= r_fill[w_q] - FW'(1);
                    if (w_cnt_inc >= i_weights[w_q]) begin
                        r_cur <= f_next_q(w_q);
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= w_cnt_inc;
                    end
                end
            end
        end
    end

    assign o_out_value = r_out_value;
    assign o_status    = r_out_status;
    assign o_out_queue = r_out_queue;

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_req == REQ_TAKE) && w_found) |-> (r_fill[w_q] != '0))
        else $error("take from an empty queue");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[r_cur] <= FW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_fresh_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_found && !w_start_ok) |-> (w_cnt == '0))
        else $error("new turn without a fresh count");

endmodule

// ----- rtl/weighted_round_robin_queues.sv -----
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_req_type, i_item_value, i_queue_select
// out       output     o_out_valid / i_out_ready  o_out_value, o_status, o_out_queue
// config    input      APB psel/penable/pwrite    paddr, pwdata, prdata (weights, 4*i)
//
// Each item is accepted, then the queue search and the queue memory access run in EXEC,
// then the result loads into the output register in DONE, past the registered memory read.
// DONE may already accept the next item while the result loads, if the output is free.
// Reset is synchronous, active low; queue memory contents are not cleared.
// A stalled output holds the finished result and the next item may already be accepted.
module weighted_round_robin_queues #(
    parameter int NUM_QUEUES  = wrrq_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = wrrq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  wrrq_pkg::t_req                  i_req_type,
    input  logic [wrrq_pkg::DATA_WIDTH-1:0] i_item_value,
    input  logic [wrrq_pkg::QSEL_W-1:0]     i_queue_select,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [wrrq_pkg::DATA_WIDTH-1:0] o_out_value,
    output wrrq_pkg::t_status               o_status,
    output logic [wrrq_pkg::QSEL_W-1:0]     o_out_queue,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wrrq_pkg::APB_AW-1:0]     paddr,
    input  logic [wrrq_pkg::APB_DW-1:0]     pwdata,
    output logic [wrrq_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import wrrq_pkg::*;

    localparam int RIW = $clog2(NUM_WEIGHT_REGS);

    t_weight                               r_weight [NUM_WEIGHT_REGS];
    logic [NUM_QUEUES-1:0][WEIGHT_W-1:0]   w_weights;
    logic [RIW-1:0]                        w_reg_idx;
    logic                                  w_wr;
    t_dp_cmd                               w_cmd;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[RIW+1:2];
    assign w_wr      = psel && penable && pwrite && pready;
    assign prdata    = APB_DW'(r_weight[w_reg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WEIGHT_REGS; i++) begin
                r_weight[i] <= WEIGHT_RESET;
            end
        end else if (w_wr && (32'(w_reg_idx) < 32'(NUM_QUEUES))) begin
            r_weight[w_reg_idx] <= pwdata[WEIGHT_W-1:0];
        end
    end

    always_comb begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (q < NUM_WEIGHT_REGS) begin
                w_weights[q] = r_weight[q];
            end else begin
                w_weights[q] = WEIGHT_RESET;
            end
        end
    end

    wrrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    wrrq_dp #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req_type     (i_req_type),
        .i_item_value   (i_item_value),
        .i_queue_select (i_queue_select),
        .i_weights      (w_weights),
        .o_out_value    (o_out_value),
        .o_status       (o_status),
        .o_out_queue    (o_out_queue)
    );

endmodule
